FILE: design/co2p_pkg.sv
// Shared types, codes and the fixed request frame of the CO2 poll engine.
`default_nettype none
package co2p_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_POLL = 2'd0;
   localparam logic [1:0] CMD_BYTE = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // result kinds
   localparam logic KIND_TX      = 1'b0;
   localparam logic KIND_OUTCOME = 1'b1;

   // poll outcome status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

   // frame geometry
   localparam int FRAME_LEN = 9;
   localparam logic [3:0] FRAME_LAST = 4'(FRAME_LEN - 1);
   localparam logic [3:0] PPM_HIGH_IDX = 4'd2;
   localparam logic [3:0] PPM_LOW_IDX  = 4'd3;
   localparam logic [3:0] SUM_FIRST_IDX = 4'd1;
   localparam logic [3:0] SUM_LAST_IDX  = 4'd7;

   localparam logic [15:0] TIMEOUT_RESET = 16'd50;
   localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

   // one pending result event from the poll core to the sender
   typedef struct packed {
      logic       valid;
      logic       is_frame;      // send the nine-word request
      logic       reading_valid;
      logic [15:0] co2_ppm;
      logic [1:0] poll_status;
   } event_type;

   // request frame FF 01 86 00 00 00 00 00 79
   function automatic logic [7:0] frame_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0: b = 8'hFF;
         4'd1: b = 8'h01;
         4'd2: b = 8'h86;
         4'd8: b = 8'h79;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: design/co2p_req_if.sv
// Request channel interface: command words into the poll engine.
`default_nettype none
interface co2p_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: design/co2p_rsp_if.sv
// Result channel interface: transmit bytes and poll outcomes.
`default_nettype none
interface co2p_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  tx_byte;
   logic        last_tx;
   logic        reading_valid;
   logic [15:0] co2_ppm;
   logic [1:0]  poll_status;

   modport source (output valid, output result_kind, output tx_byte, output last_tx,
                   output reading_valid, output co2_ppm, output poll_status,
                   input ready);
   modport sink   (input valid, input result_kind, input tx_byte, input last_tx,
                   input reading_valid, input co2_ppm, input poll_status,
                   output ready);
endinterface
`default_nettype wire

FILE: design/co2p_poll_core.sv
// Poll state: response byte counting, checksum, reading capture and timeout.
`default_nettype none
module co2p_poll_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [1:0]  command,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [15:0] timeout_ticks,
   output co2p_pkg::event_type evt
);

   logic        waiting_ff, waiting_in;
   logic [3:0]  bytes_seen_ff, bytes_seen_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  ppm_high_ff, ppm_high_in;
   logic [7:0]  ppm_low_ff, ppm_low_in;
   logic [15:0] ticks_waited_ff, ticks_waited_in;
   logic [7:0]  expect_sum;

   // checksum: two's complement of the sum of bytes 1..7
   assign expect_sum = 8'(8'd0 - running_sum_ff);

   // next state and result event for the accepted word
   always_comb begin
      waiting_in      = waiting_ff;
      bytes_seen_in   = bytes_seen_ff;
      running_sum_in  = running_sum_ff;
      ppm_high_in     = ppm_high_ff;
      ppm_low_in      = ppm_low_ff;
      ticks_waited_in = ticks_waited_ff;
      evt             = '0;
      if (accept) begin
         case (command)
            co2p_pkg::CMD_POLL: begin
               waiting_in      = 1'b1;
               bytes_seen_in   = '0;
               running_sum_in  = '0;
               ticks_waited_in = '0;
               evt.valid       = 1'b1;
               evt.is_frame    = 1'b1;
            end
            co2p_pkg::CMD_BYTE: begin
               if (waiting_ff) begin
                  if (bytes_seen_ff >= co2p_pkg::SUM_FIRST_IDX &&
                      bytes_seen_ff <= co2p_pkg::SUM_LAST_IDX) begin
                     running_sum_in = 8'(running_sum_ff + rx_byte);
                  end
                  if (bytes_seen_ff == co2p_pkg::PPM_HIGH_IDX) begin
                     ppm_high_in = rx_byte;
                  end
                  if (bytes_seen_ff == co2p_pkg::PPM_LOW_IDX) begin
                     ppm_low_in = rx_byte;
                  end
                  bytes_seen_in = 4'(bytes_seen_ff + 4'd1);
                  if (bytes_seen_ff == co2p_pkg::FRAME_LAST) begin
                     waiting_in = 1'b0;
                     evt.valid  = 1'b1;
                     if (rx_byte == expect_sum) begin
                        evt.reading_valid = 1'b1;
                        evt.co2_ppm       = {ppm_high_ff, ppm_low_ff};
                        evt.poll_status   = co2p_pkg::STATUS_OK;
                     end else begin
                        evt.poll_status = co2p_pkg::STATUS_CHECKSUM;
                     end
                  end
               end
            end
            co2p_pkg::CMD_TICK: begin
               if (waiting_ff) begin
                  if (ticks_waited_ff != co2p_pkg::TICKS_MAX) begin
                     ticks_waited_in = 16'(ticks_waited_ff + 16'd1);
                  end
                  if (ticks_waited_in >= timeout_ticks) begin
                     waiting_in      = 1'b0;
                     evt.valid       = 1'b1;
                     evt.poll_status = co2p_pkg::STATUS_TIMEOUT;
                  end
               end
            end
            default: begin
               // unused command code: no effect
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff      <= 1'b0;
         bytes_seen_ff   <= '0;
         running_sum_ff  <= '0;
         ticks_waited_ff <= '0;
      end else begin
         waiting_ff      <= waiting_in;
         bytes_seen_ff   <= bytes_seen_in;
         running_sum_ff  <= running_sum_in;
         ticks_waited_ff <= ticks_waited_in;
      end
   end

   // captured reading bytes
   always_ff @(posedge clock) begin
      ppm_high_ff <= ppm_high_in;
      ppm_low_ff  <= ppm_low_in;
   end

endmodule
`default_nettype wire

FILE: design/co2p_rsp_sender.sv
// Result register: holds one event and sends it as one outcome word or nine frame words.
`default_nettype none
module co2p_rsp_sender (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire co2p_pkg::event_type evt,
   output logic                     can_take,
   co2p_rsp_if.source               rsp_ch
);

   logic                valid_ff, valid_in;
   co2p_pkg::event_type evt_ff, evt_in;
   logic [3:0]          word_idx_ff, word_idx_in;
   logic                word_taken;
   logic                done;

   assign word_taken = valid_ff && rsp_ch.ready;
   assign done       = word_taken && (!evt_ff.is_frame || word_idx_ff == co2p_pkg::FRAME_LAST);
   assign can_take   = !valid_ff || done;

   // load a new event, step through the frame, or drain
   always_comb begin
      valid_in    = valid_ff;
      evt_in      = evt_ff;
      word_idx_in = word_idx_ff;
      if (evt.valid) begin
         valid_in    = 1'b1;
         evt_in      = evt;
         word_idx_in = '0;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (word_taken) begin
         word_idx_in = 4'(word_idx_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         word_idx_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         word_idx_ff <= word_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
   end

   // result word fields
   always_comb begin
      rsp_ch.valid = valid_ff;
      if (evt_ff.is_frame) begin
         rsp_ch.result_kind   = co2p_pkg::KIND_TX;
         rsp_ch.tx_byte       = co2p_pkg::frame_byte(word_idx_ff);
         rsp_ch.last_tx       = (word_idx_ff == co2p_pkg::FRAME_LAST);
         rsp_ch.reading_valid = 1'b0;
         rsp_ch.co2_ppm       = '0;
         rsp_ch.poll_status   = co2p_pkg::STATUS_OK;
      end else begin
         rsp_ch.result_kind   = co2p_pkg::KIND_OUTCOME;
         rsp_ch.tx_byte       = '0;
         rsp_ch.last_tx       = 1'b0;
         rsp_ch.reading_valid = evt_ff.reading_valid;
         rsp_ch.co2_ppm       = evt_ff.co2_ppm;
         rsp_ch.poll_status   = evt_ff.poll_status;
      end
   end

endmodule
`default_nettype wire

FILE: design/co2_sensor_uart_poll_engine_unit.sv
// Top level of the CO2 sensor nine-byte UART poll engine.
//
//   channel  | dir | contents
//   ---------+-----+------------------------------------------------------
//   req_ch   | in  | command, rx_byte (valid/ready)
//   rsp_ch   | out | result_kind, tx_byte, last_tx, reading_valid,
//            |     | co2_ppm, poll_status (valid/ready)
//   csr_*    | in  | timeout_ticks write, no read-back
//
// A word is processed in the cycle it is accepted; its result word is in the
// output register the next cycle. A poll sends nine words, one per cycle while
// rsp_ch.ready is high. req_ch.ready is high when the output register is empty
// or its last word is being taken, so words arrive back to back with no gap.
// Words that give no result still wait for a free output register.
// Synchronous reset clears the poll control state and sets timeout_ticks to 50.
`default_nettype none
module co2_sensor_uart_poll_engine_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   co2p_req_if.sink         req_ch,
   co2p_rsp_if.source       rsp_ch,
   input  wire logic        csr_write_en,
   input  wire logic [15:0] csr_write_data
);

   logic [15:0]         timeout_ticks_ff;
   logic                can_take;
   logic                accept;
   co2p_pkg::event_type evt;

   assign req_ch.ready = can_take;
   assign accept       = req_ch.valid && can_take;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= co2p_pkg::TIMEOUT_RESET;
      end else if (csr_write_en) begin
         timeout_ticks_ff <= csr_write_data;
      end
   end

   co2p_poll_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_ch.command),
      .rx_byte       (req_ch.rx_byte),
      .timeout_ticks (timeout_ticks_ff),
      .evt           (evt)
   );

   co2p_rsp_sender u_sender (
      .clock    (clock),
      .reset    (reset),
      .evt      (evt),
      .can_take (can_take),
      .rsp_ch   (rsp_ch)
   );

endmodule
`default_nettype wire
